// File: design/shd_pkg.sv
// Package for the submersion hysteresis debouncer.
// Holds the shared register, mode and status types and the reset constants.
// It has no dependencies; the core and the top level both use it.
package shd_pkg;

    localparam int unsigned LevelWidth = 12;
    localparam int unsigned RawWidth   = 12;
    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned CountWidth = 16;
    localparam int unsigned ModeWidth  = 2;
    localparam int unsigned AddrWidth  = 3;
    localparam int unsigned CfgDataWidth = 32;

    // Register indexes on the configuration port.
    localparam logic [AddrWidth-1:0] RegEnterThreshold = 3'd0;
    localparam logic [AddrWidth-1:0] RegExitThreshold  = 3'd1;
    localparam logic [AddrWidth-1:0] RegMinWetTime     = 3'd2;
    localparam logic [AddrWidth-1:0] RegMinDryTime     = 3'd3;
    localparam logic [AddrWidth-1:0] RegMinSampleCount = 3'd4;
    localparam logic [AddrWidth-1:0] RegEvidenceMode   = 3'd5;

    // How the level comparison and the wet contact are combined.
    typedef enum logic [ModeWidth-1:0] {
        MODE_LEVEL  = 2'd0,
        MODE_WET    = 2'd1,
        MODE_BOTH   = 2'd2,
        MODE_EITHER = 2'd3
    } evid_sel_t;

    localparam logic [LevelWidth-1:0] EnterThresholdReset = 12'd819;
    localparam logic [LevelWidth-1:0] ExitThresholdReset  = 12'd492;
    localparam logic [TimeWidth-1:0]  MinWetTimeReset     = 32'd1200;
    localparam logic [TimeWidth-1:0]  MinDryTimeReset     = 32'd700;
    localparam logic [CountWidth-1:0] MinSampleCountReset = 16'd3;

    localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

    typedef struct packed {
        logic [LevelWidth-1:0] enter_threshold;
        logic [LevelWidth-1:0] exit_threshold;
        logic [TimeWidth-1:0]  wet_hold_ms;
        logic [TimeWidth-1:0]  dry_hold_ms;
        logic [CountWidth-1:0] min_sample_count;
        evid_sel_t             evid_sel;
    } shd_cfg_t;

    // Status produced by the core for one sample.
    typedef struct packed {
        logic                  submerged;
        logic                  candidate_wet;
        logic [TimeWidth-1:0]  candidate_age_ms;
        logic [CountWidth-1:0] agree_count;
    } shd_status_t;

endpackage

// File: design/shd_core.sv
// Debounce core of the submersion hysteresis debouncer.
// Holds the stable and candidate state and computes one sample's status.
// Depends on shd_pkg.
module shd_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  shd_pkg::shd_cfg_t             cfg,
    input  logic [shd_pkg::LevelWidth-1:0] level,
    input  logic                          wet,
    input  logic [shd_pkg::TimeWidth-1:0] now_ms,
    output shd_pkg::shd_status_t          status
);

    logic                           stable_wet_reg, stable_wet_next;
    logic                           cand_state_reg, cand_state_next;
    logic                           cand_valid_reg, cand_valid_next;
    logic [shd_pkg::TimeWidth-1:0]  cand_start_reg, cand_start_next;
    logic [shd_pkg::CountWidth-1:0] sample_count_reg, sample_count_next;

    logic [shd_pkg::LevelWidth-1:0] thr_hi, thr_lo, thr;
    logic                           by_level;
    logic                           cand;
    logic                           new_cand;
    logic [shd_pkg::CountWidth-1:0] need_cnt;
    logic [shd_pkg::TimeWidth-1:0]  need_time;
    logic [shd_pkg::TimeWidth-1:0]  age;
    logic                           promote;

    always_comb begin
        // The larger threshold is always the entry level, the smaller the exit level.
        if (cfg.enter_threshold >= cfg.exit_threshold) begin
            thr_hi = cfg.enter_threshold;
            thr_lo = cfg.exit_threshold;
        end else begin
            thr_hi = cfg.exit_threshold;
            thr_lo = cfg.enter_threshold;
        end
        thr      = stable_wet_reg ? thr_lo : thr_hi;
        by_level = (level >= thr);

        case (cfg.evid_sel)
            shd_pkg::MODE_LEVEL:  cand = by_level;
            shd_pkg::MODE_WET:    cand = wet;
            shd_pkg::MODE_BOTH:   cand = by_level & wet;
            shd_pkg::MODE_EITHER: cand = by_level | wet;
            default:              cand = by_level | wet;
        endcase

        new_cand = !cand_valid_reg || (cand != cand_state_reg);

        cand_valid_next = 1'b1;
        cand_state_next = cand;
        if (new_cand) begin
            cand_start_next   = now_ms;
            sample_count_next = shd_pkg::CountWidth'(1);
        end else begin
            cand_start_next = cand_start_reg;
            if (sample_count_reg < shd_pkg::CountMax) begin
                sample_count_next = sample_count_reg + shd_pkg::CountWidth'(1);
            end else begin
                sample_count_next = sample_count_reg;
            end
        end

        age = now_ms - cand_start_next;

        // A count of zero behaves as one.
        if (cfg.min_sample_count == '0) begin
            need_cnt = shd_pkg::CountWidth'(1);
        end else begin
            need_cnt = cfg.min_sample_count;
        end
        need_time = cand ? cfg.wet_hold_ms : cfg.dry_hold_ms;

        promote = (cand != stable_wet_reg) && (sample_count_next >= need_cnt)
                  && (age >= need_time);
        stable_wet_next = promote ? cand : stable_wet_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_wet_reg   <= 1'b0;
            cand_state_reg   <= 1'b0;
            cand_valid_reg   <= 1'b0;
            cand_start_reg   <= '0;
            sample_count_reg <= '0;
        end else if (step) begin
            stable_wet_reg   <= stable_wet_next;
            cand_state_reg   <= cand_state_next;
            cand_valid_reg   <= cand_valid_next;
            cand_start_reg   <= cand_start_next;
            sample_count_reg <= sample_count_next;
        end
    end

    assign status.submerged        = stable_wet_next;
    assign status.candidate_wet    = cand_state_next;
    assign status.candidate_age_ms = age;
    assign status.agree_count      = sample_count_next;

`ifndef SYNTHESIS
    // A fresh candidate restarts its count at one and its clock at this sample.
    a_new_cand_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        step && new_cand |=> sample_count_reg == shd_pkg::CountWidth'(1)
                             && cand_start_reg == $past(now_ms))
        else $error("new candidate did not restart count and start time");

    // Once a candidate exists its run count is never zero.
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cand_valid_reg |-> sample_count_reg != '0)
        else $error("candidate valid with zero count");

    // The stable state only ever moves onto the current candidate.
    a_stable_follows_cand: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (stable_wet_next != stable_wet_reg) |=> stable_wet_reg == cand_state_reg)
        else $error("stable state changed away from candidate");

    // Without a sample the debounce state holds.
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(stable_wet_reg) && $stable(sample_count_reg))
        else $error("debounce state changed without a sample");
`endif

endmodule

// File: design/submersion_hysteresis_debouncer.sv
// Top level of the submersion hysteresis debouncer.
// Holds the stream ports, configuration registers and the input and result registers.
// Depends on shd_pkg and shd_core.

// Each input word is one water-level sample and produces exactly one status word.
// A sample waits in the input register, the debounce core updates its state as
// the sample moves into the result register, and the result waits there until
// the sink takes it. The block sustains one word per cycle while the sink does
// not stall: the only loop is the state update in the core (a 12-bit threshold
// compare, a 32-bit age subtract and compare, and a 16-bit count compare). The
// level is compared with the larger threshold while the stable state is dry and
// with the smaller one while it is submerged; the candidate becomes stable once
// it has agreed on enough consecutive samples and has lasted the wet or dry
// minimum time. Configuration registers may be written only while no sample is
// in flight.
module submersion_hysteresis_debouncer (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // level[11:0], wet[12], raw_reading[24:13], sample_ms[56:25], zero fill above
    input  logic [63:0]                        s_tdata,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // submerged[0], candidate_wet[1], raw_out[13:2], level_out[25:14],
    // time_out[57:26], candidate_age_ms[89:58], agree_count[105:90], zero fill above
    output logic [111:0]                       m_tdata,

    input  logic                               cfg_wr_en,
    input  logic [shd_pkg::AddrWidth-1:0]      cfg_addr,
    input  logic [shd_pkg::CfgDataWidth-1:0]   cfg_wr_data
);

    // Configuration registers.
    shd_pkg::shd_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enter_threshold  <= shd_pkg::EnterThresholdReset;
            cfg_reg.exit_threshold   <= shd_pkg::ExitThresholdReset;
            cfg_reg.wet_hold_ms      <= shd_pkg::MinWetTimeReset;
            cfg_reg.dry_hold_ms      <= shd_pkg::MinDryTimeReset;
            cfg_reg.min_sample_count <= shd_pkg::MinSampleCountReset;
            cfg_reg.evid_sel         <= shd_pkg::MODE_EITHER;
        end else if (cfg_wr_en) begin
            // Writes to unused indexes are dropped.
            case (cfg_addr)
                shd_pkg::RegEnterThreshold:
                    cfg_reg.enter_threshold <= cfg_wr_data[shd_pkg::LevelWidth-1:0];
                shd_pkg::RegExitThreshold:
                    cfg_reg.exit_threshold <= cfg_wr_data[shd_pkg::LevelWidth-1:0];
                shd_pkg::RegMinWetTime:
                    cfg_reg.wet_hold_ms <= cfg_wr_data[shd_pkg::TimeWidth-1:0];
                shd_pkg::RegMinDryTime:
                    cfg_reg.dry_hold_ms <= cfg_wr_data[shd_pkg::TimeWidth-1:0];
                shd_pkg::RegMinSampleCount:
                    cfg_reg.min_sample_count <= cfg_wr_data[shd_pkg::CountWidth-1:0];
                shd_pkg::RegEvidenceMode:
                    cfg_reg.evid_sel <=
                        shd_pkg::evid_sel_t'(cfg_wr_data[shd_pkg::ModeWidth-1:0]);
                default: ;
            endcase
        end
    end

    // Input register. A new word is taken whenever the slot is empty or is
    // emptying into the result register in the same cycle.
    logic                            in_valid_reg;
    logic [shd_pkg::LevelWidth-1:0]  in_level_reg;
    logic                            in_wet_reg;
    logic [shd_pkg::RawWidth-1:0]    in_raw_reg;
    logic [shd_pkg::TimeWidth-1:0]   in_time_reg;

    logic out_load;
    logic in_load;

    // The result register can load when it is empty or its word is being taken.
    assign out_load = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_level_reg <= s_tdata[11:0];
            in_wet_reg   <= s_tdata[12];
            in_raw_reg   <= s_tdata[24:13];
            in_time_reg  <= s_tdata[56:25];
        end
    end

    shd_pkg::shd_status_t status;

    shd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (out_load),
        .cfg     (cfg_reg),
        .level   (in_level_reg),
        .wet     (in_wet_reg),
        .now_ms  (in_time_reg),
        .status  (status)
    );

    // Result register.
    logic                            out_valid_reg;
    shd_pkg::shd_status_t            out_status_reg;
    logic [shd_pkg::RawWidth-1:0]    out_raw_reg;
    logic [shd_pkg::LevelWidth-1:0]  out_level_reg;
    logic [shd_pkg::TimeWidth-1:0]   out_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= status;
            out_raw_reg    <= in_raw_reg;
            out_level_reg  <= in_level_reg;
            out_time_reg   <= in_time_reg;
        end
    end

    assign m_tvalid          = out_valid_reg;
    assign m_tdata[0]        = out_status_reg.submerged;
    assign m_tdata[1]        = out_status_reg.candidate_wet;
    assign m_tdata[13:2]     = out_raw_reg;
    assign m_tdata[25:14]    = out_level_reg;
    assign m_tdata[57:26]    = out_time_reg;
    assign m_tdata[89:58]    = out_status_reg.candidate_age_ms;
    assign m_tdata[105:90]   = out_status_reg.agree_count;
    assign m_tdata[111:106]  = '0;

endmodule

// File: sim/submersion_hysteresis_debouncer_test.sv
// Self-checking testbench for the submersion hysteresis debouncer.
// Drives samples on the stream input, predicts every status word and checks it.
// Depends on shd_pkg and the submersion_hysteresis_debouncer top level.
module submersion_hysteresis_debouncer_test;

    // Cycles without any handshake or register write before the run is declared hung.
    localparam int unsigned StallLimit = 5000;

    // Indexes beyond the register file; writes to them must change nothing.
    localparam logic [shd_pkg::AddrWidth-1:0] RegSpareLow  = 3'd6;
    localparam logic [shd_pkg::AddrWidth-1:0] RegSpareHigh = 3'd7;

    // One input word, last field in the lowest bits.
    typedef struct packed {
        logic [shd_pkg::TimeWidth-1:0]  sample_ms;
        logic [shd_pkg::RawWidth-1:0]   raw_reading;
        logic                           wet;
        logic [shd_pkg::LevelWidth-1:0] level;
    } sample_t;

    // One result word, last field in the lowest bits.
    typedef struct packed {
        logic [shd_pkg::CountWidth-1:0] agree_count;
        logic [shd_pkg::TimeWidth-1:0]  candidate_age_ms;
        logic [shd_pkg::TimeWidth-1:0]  time_out;
        logic [shd_pkg::LevelWidth-1:0] level_out;
        logic [shd_pkg::RawWidth-1:0]   raw_out;
        logic                           candidate_wet;
        logic                           submerged;
    } status_word_t;

    // Keeps its own copy of the registers and the debounce state, works out the
    // status word for every accepted sample and compares the words that come out.
    class debounce_scoreboard;
        logic [shd_pkg::LevelWidth-1:0] enter_thr;
        logic [shd_pkg::LevelWidth-1:0] exit_thr;
        logic [shd_pkg::TimeWidth-1:0]  wet_time_ms;
        logic [shd_pkg::TimeWidth-1:0]  dry_time_ms;
        logic [shd_pkg::CountWidth-1:0] need_samples;
        shd_pkg::evid_sel_t             mode;
        logic                           stable_wet;
        logic                           cand_wet;
        logic                           cand_seen;
        logic [shd_pkg::TimeWidth-1:0]  cand_start_ms;
        logic [shd_pkg::CountWidth-1:0] agree_count;
        status_word_t                   status_q[$];
        int unsigned                    failures;

        function new();
            enter_thr     = shd_pkg::EnterThresholdReset;
            exit_thr      = shd_pkg::ExitThresholdReset;
            wet_time_ms   = shd_pkg::MinWetTimeReset;
            dry_time_ms   = shd_pkg::MinDryTimeReset;
            need_samples  = shd_pkg::MinSampleCountReset;
            mode          = shd_pkg::MODE_EITHER;
            stable_wet    = 1'b0;
            cand_wet      = 1'b0;
            cand_seen     = 1'b0;
            cand_start_ms = '0;
            agree_count   = '0;
            failures      = 0;
        endfunction

        function void write_reg(logic [shd_pkg::AddrWidth-1:0] index,
                                logic [shd_pkg::CfgDataWidth-1:0] value);
            case (index)
                shd_pkg::RegEnterThreshold: enter_thr   = value[shd_pkg::LevelWidth-1:0];
                shd_pkg::RegExitThreshold:  exit_thr    = value[shd_pkg::LevelWidth-1:0];
                shd_pkg::RegMinWetTime:     wet_time_ms = value[shd_pkg::TimeWidth-1:0];
                shd_pkg::RegMinDryTime:     dry_time_ms = value[shd_pkg::TimeWidth-1:0];
                shd_pkg::RegMinSampleCount:
                    need_samples = value[shd_pkg::CountWidth-1:0];
                shd_pkg::RegEvidenceMode:
                    mode = shd_pkg::evid_sel_t'(value[shd_pkg::ModeWidth-1:0]);
                default: ;
            endcase
        endfunction

        function void note_sample(sample_t smp);
            logic [shd_pkg::LevelWidth-1:0] upper;
            logic [shd_pkg::LevelWidth-1:0] lower;
            logic [shd_pkg::LevelWidth-1:0] thr;
            logic                           by_level;
            logic                           cand;
            logic [shd_pkg::CountWidth-1:0] need;
            logic [shd_pkg::TimeWidth-1:0]  need_ms;
            status_word_t                   st;
            // Whichever register is larger acts as the enter threshold.
            upper = (enter_thr >= exit_thr) ? enter_thr : exit_thr;
            lower = (enter_thr >= exit_thr) ? exit_thr : enter_thr;
            thr = stable_wet ? lower : upper;
            by_level = (smp.level >= thr);
            case (mode)
                shd_pkg::MODE_LEVEL: cand = by_level;
                shd_pkg::MODE_WET:   cand = smp.wet;
                shd_pkg::MODE_BOTH:  cand = by_level && smp.wet;
                default:             cand = by_level || smp.wet;
            endcase
            need = (need_samples == 0) ? 16'd1 : need_samples;
            if (!cand_seen || cand != cand_wet) begin
                cand_seen     = 1'b1;
                cand_wet      = cand;
                cand_start_ms = smp.sample_ms;
                agree_count   = 16'd1;
            end else if (agree_count != shd_pkg::CountMax) begin
                agree_count = agree_count + 16'd1;
            end
            st.candidate_age_ms = smp.sample_ms - cand_start_ms;
            need_ms = cand_wet ? wet_time_ms : dry_time_ms;
            if (cand_wet != stable_wet && agree_count >= need && st.candidate_age_ms >= need_ms)
                stable_wet = cand_wet;
            st.submerged     = stable_wet;
            st.candidate_wet = cand_wet;
            st.raw_out       = smp.raw_reading;
            st.level_out     = smp.level;
            st.time_out      = smp.sample_ms;
            st.agree_count   = agree_count;
            status_q.push_back(st);
        endfunction

        function void check_status(status_word_t got);
            status_word_t want;
            if (status_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: status word %h arrived with nothing expected", $time, got);
                return;
            end
            want = status_q.pop_front();
            if (got.submerged !== want.submerged || got.candidate_wet !== want.candidate_wet ||
                got.raw_out !== want.raw_out || got.level_out !== want.level_out ||
                got.time_out !== want.time_out ||
                got.candidate_age_ms !== want.candidate_age_ms ||
                got.agree_count !== want.agree_count) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0t: status mismatch (sub cand raw level time age count)", $time);
                    $display("  expected %0d %0d %0d %0d %0d %0d %0d", want.submerged,
                             want.candidate_wet, want.raw_out, want.level_out, want.time_out,
                             want.candidate_age_ms, want.agree_count);
                    $display("  actual   %0d %0d %0d %0d %0d %0d %0d", got.submerged,
                             got.candidate_wet, got.raw_out, got.level_out, got.time_out,
                             got.candidate_age_ms, got.agree_count);
                end
            end
        endfunction

        function int unsigned pending();
            return status_q.size();
        endfunction
    endclass

    logic                             aclk        = 1'b0;
    logic                             aresetn     = 1'b0;
    logic                             s_tvalid    = 1'b0;
    logic                             s_tready;
    logic [63:0]                      s_tdata     = '0;
    logic                             m_tvalid;
    logic                             m_tready    = 1'b0;
    logic [111:0]                     m_tdata;
    logic                             cfg_wr_en   = 1'b0;
    logic [shd_pkg::AddrWidth-1:0]    cfg_addr    = '0;
    logic [shd_pkg::CfgDataWidth-1:0] cfg_wr_data = '0;

    debounce_scoreboard sb;
    int unsigned        send_idle_pct = 0;   // chance in percent of an idle cycle before a word
    int unsigned        stall_pct     = 0;   // chance in percent that the sink holds off a cycle
    int unsigned        quiet_cycles  = 0;
    logic [31:0]        clock_ms      = '0;  // running sample time for the random part

    submersion_hysteresis_debouncer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The sink stalls at random with the rate of the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Both handshakes are observed at the clock edge, so the scoreboard sees exactly
    // the values the block saw. An input word is noted before a result is checked;
    // the input and result registers lie between, so no word ends at its accept edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_sample(sample_t'(s_tdata[$bits(sample_t)-1:0]));
            if (m_tvalid && m_tready)
                sb.check_status(status_word_t'(m_tdata[$bits(status_word_t)-1:0]));
        end
    end

    // Any handshake or register write counts as progress. A long stretch without
    // either means the block has hung.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("%0t: no handshake for %0d cycles", $time, StallLimit);
            $display("** submersion_hysteresis_debouncer: FAILED **");
            $finish;
        end
    end

    function automatic sample_t make_sample(logic [11:0] level, logic wet, logic [11:0] raw,
                                            logic [31:0] ts);
        sample_t smp;
        smp.level       = level;
        smp.wet         = wet;
        smp.raw_reading = raw;
        smp.sample_ms   = ts;
        return smp;
    endfunction

    // A register value that is zero, all ones, typical or anything at all.
    function automatic logic [31:0] pick_value(int unsigned bits, int unsigned typical);
        logic [31:0] all_ones;
        all_ones = 32'hFFFF_FFFF >> (32 - bits);
        case ($urandom_range(5))
            0:       return '0;
            1:       return all_ones;
            2, 3:    return $urandom_range(typical, 1);
            default: return $urandom() & all_ones;
        endcase
    endfunction

    // Builds one random sample that leans toward the intended state. The level is
    // chosen against the current thresholds so that runs of agreeing samples form,
    // with some levels right at a threshold and some entirely random. Time mostly
    // moves forward in modest steps, sometimes jumps, steps back or nears the wrap.
    function automatic sample_t random_sample(logic intent_wet);
        logic [11:0] upper;
        logic [11:0] lower;
        sample_t     smp;
        upper = (sb.enter_thr >= sb.exit_thr) ? sb.enter_thr : sb.exit_thr;
        lower = (sb.enter_thr >= sb.exit_thr) ? sb.exit_thr : sb.enter_thr;
        case ($urandom_range(9))
            0:       smp.level = 12'($urandom_range(4095));
            1:       smp.level = intent_wet ? upper : lower - 12'd1;
            2:       smp.level = intent_wet ? lower : upper - 12'd1;
            default: begin
                if (intent_wet)
                    smp.level = 12'($urandom_range(4095, upper));
                else
                    smp.level = (lower == 0) ? 12'd0 : 12'($urandom_range(lower - 1, 0));
            end
        endcase
        smp.wet = ($urandom_range(9) < 8) ? intent_wet : 1'($urandom_range(1));
        smp.raw_reading = 12'($urandom_range(4095));
        case ($urandom_range(19))
            0:       clock_ms = clock_ms - $urandom_range(2000);
            1:       clock_ms = $urandom();
            2:       clock_ms = 32'hFFFF_FFFF - $urandom_range(1500);
            3, 4:    clock_ms = clock_ms + $urandom_range(3000);
            default: clock_ms = clock_ms + $urandom_range(600);
        endcase
        smp.sample_ms = clock_ms;
        return smp;
    endfunction

    // Offers one word after a random gap and returns at the edge where it is taken.
    // The valid stays high on return, so a word that follows at once is not split by
    // a low cycle; whoever pauses next lowers it in the same time step.
    task automatic send_sample(input sample_t smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, smp};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Stops sending and waits until every expected status word has been taken, then
    // lets the requested number of extra cycles pass. The first edge lets the monitor
    // note a word accepted at the edge this task was called from.
    task automatic drain_block(input int unsigned extra_cycles);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (extra_cycles) @(posedge aclk);
    endtask

    task automatic write_register(input logic [shd_pkg::AddrWidth-1:0] index,
                                  input logic [shd_pkg::CfgDataWidth-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= index;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.write_reg(index, value);
    endtask

    // Writes all six registers once the block is idle. A write to an index past the
    // register file comes last, so any aliasing onto a real register would show up.
    task automatic apply_settings(input logic [11:0] enter_thr, input logic [11:0] exit_thr,
                                  input logic [31:0] wet_ms, input logic [31:0] dry_ms,
                                  input logic [15:0] need_samples,
                                  input shd_pkg::evid_sel_t mode);
        drain_block(4);
        write_register(shd_pkg::RegEnterThreshold, 32'(enter_thr));
        write_register(shd_pkg::RegExitThreshold, 32'(exit_thr));
        write_register(shd_pkg::RegMinWetTime, wet_ms);
        write_register(shd_pkg::RegMinDryTime, dry_ms);
        write_register(shd_pkg::RegMinSampleCount, 32'(need_samples));
        write_register(shd_pkg::RegEvidenceMode, 32'(mode));
        write_register($urandom_range(1) ? RegSpareLow : RegSpareHigh, $urandom());
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int unsigned sent;
        int unsigned run_len;
        logic        intent_wet;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: either evidence, thresholds 819 and 492, 1200 ms wet,
        // 700 ms dry, three samples. The first sample opens the first candidate.
        send_sample(make_sample(12'd0, 1'b0, 12'd0, 32'd0));
        send_sample(make_sample(12'd0, 1'b0, 12'd4095, 32'd100));
        send_sample(make_sample(12'd818, 1'b0, 12'd1, 32'd200));
        // A level exactly at the enter threshold turns the candidate wet; it is
        // promoted when the count is met and the age is exactly the wet minimum.
        send_sample(make_sample(12'd819, 1'b0, 12'd2, 32'd300));
        send_sample(make_sample(12'd4095, 1'b1, 12'd3, 32'd900));
        send_sample(make_sample(12'd2000, 1'b0, 12'd4, 32'd1500));
        // While submerged the lower threshold applies: 492 stays wet, 491 goes dry.
        send_sample(make_sample(12'd492, 1'b0, 12'd5, 32'd1600));
        send_sample(make_sample(12'd491, 1'b0, 12'd6, 32'd1700));
        send_sample(make_sample(12'd100, 1'b0, 12'd7, 32'd1800));
        send_sample(make_sample(12'd100, 1'b0, 12'd8, 32'd2400));
        // The wet contact alone is enough in either mode. Time then goes backward,
        // which makes the age wrap to a huge value, and then to the top of the range.
        send_sample(make_sample(12'd0, 1'b1, 12'd9, 32'd2500));
        send_sample(make_sample(12'd0, 1'b1, 12'd10, 32'd10));
        send_sample(make_sample(12'd0, 1'b1, 12'd11, 32'hFFFF_FFFF));

        // Swapped thresholds, a sample count of zero and no minimum time: the larger
        // register acts as the enter threshold and every change promotes at once.
        apply_settings(12'd100, 12'd3000, 32'd0, 32'd0, 16'd0, shd_pkg::MODE_LEVEL);
        send_sample(make_sample(12'd2999, 1'b1, 12'd12, 32'd3000));
        send_sample(make_sample(12'd3000, 1'b0, 12'd13, 32'd3001));
        send_sample(make_sample(12'd100, 1'b0, 12'd14, 32'd3002));
        send_sample(make_sample(12'd99, 1'b1, 12'd15, 32'd3003));

        // Longest minimum times: only an age of all ones, from a timestamp one below
        // the candidate start, can promote.
        apply_settings(12'd819, 12'd492, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1,
                       shd_pkg::MODE_WET);
        send_sample(make_sample(12'd0, 1'b1, 12'd16, 32'd5000));
        send_sample(make_sample(12'd4095, 1'b1, 12'd17, 32'd4999));
        send_sample(make_sample(12'd4095, 1'b0, 12'd18, 32'd5000));

        // Both pieces of evidence required, thresholds at the ends of the range.
        apply_settings(12'd0, 12'd4095, 32'd10, 32'd10, 16'd2, shd_pkg::MODE_BOTH);
        send_sample(make_sample(12'd4095, 1'b0, 12'd19, 32'd6000));
        send_sample(make_sample(12'd4095, 1'b1, 12'd20, 32'd6010));
        send_sample(make_sample(12'd4095, 1'b1, 12'd21, 32'd6020));
        send_sample(make_sample(12'd0, 1'b1, 12'd22, 32'd6030));

        // With the largest sample count an agreeing run keeps counting up and the
        // candidate is never promoted.
        apply_settings(12'd2048, 12'd1024, 32'd0, 32'd0, 16'hFFFF, shd_pkg::MODE_LEVEL);
        for (sent = 0; sent < 40; sent++)
            send_sample(make_sample(sb.stable_wet ? 12'd0 : 12'd4095, sent[0], sent[11:0],
                                    32'd7000 + sent));

        // Random part: eight phases with fresh settings, cycling through the idle
        // patterns. Samples come in runs that lean toward one state so candidates
        // persist long enough to be promoted, mixed with short and noisy runs.
        for (int phase = 0; phase < 8; phase++) begin
            apply_settings(12'(pick_value(12, 4095)), 12'(pick_value(12, 4095)),
                           pick_value(32, 2000), pick_value(32, 2000),
                           16'(pick_value(16, 6)),
                           shd_pkg::evid_sel_t'($urandom_range(3)));
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 86;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 86;
                end
                default: begin
                    send_idle_pct = 18;
                    stall_pct     = 18;
                end
            endcase
            sent = 0;
            while (sent < 100) begin
                intent_wet = 1'($urandom_range(1));
                run_len = ($urandom_range(4) == 0) ? 1 : $urandom_range(8, 2);
                for (int k = 0; k < run_len && sent < 100; k++) begin
                    // Halfway through each phase the sender holds off until the block
                    // has handed over every outstanding status word.
                    if (sent == 50)
                        drain_block(0);
                    send_sample(random_sample(intent_wet));
                    sent++;
                end
            end
        end

        drain_block(8);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("** submersion_hysteresis_debouncer: PASSED **");
        else
            $display("** submersion_hysteresis_debouncer: FAILED **");
        $finish;
    end

endmodule
